@@ design/tbcd_pkg.sv @@
`timescale 1ns / 1ps

package tbcd_pkg;

  // Internal word widths, sized for the widest sample format (32 bits)
  localparam int STATE_W = 32;   // filter state words
  localparam int SUM_W   = 34;   // left + right + dope offset
  localparam int BAND_W  = 35;   // band value and filter differences
  localparam int MUL_A_W = 35;   // signed multiplier operand
  localparam int MUL_B_W = 32;   // unsigned multiplier operand
  localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;
  localparam int ROUND_W = 37;   // state plus rounded correction
  localparam int SIDE_W  = 36;   // rounded side term
  localparam int DEN_W   = 51;   // soft clip denominator
  localparam int TRIM_W  = 47;   // rounded trim product
  localparam int MIX_W   = 50;   // band mix accumulator
  localparam int CFG_W   = 32;
  localparam int GAIN_W  = 18;
  localparam int COEF_W  = 16;

  // Register map
  localparam logic [2:0] REG_CROSSOVER  = 3'd0;
  localparam logic [2:0] REG_DRIVE_LOW  = 3'd1;
  localparam logic [2:0] REG_DRIVE_MID  = 3'd2;
  localparam logic [2:0] REG_DRIVE_HIGH = 3'd3;
  localparam logic [2:0] REG_TRIM_LOW   = 3'd4;
  localparam logic [2:0] REG_TRIM_MID   = 3'd5;
  localparam logic [2:0] REG_TRIM_HIGH  = 3'd6;
  localparam logic [2:0] REG_SIDE_GAIN  = 3'd7;

  // Register defaults
  localparam logic [CFG_W-1:0]  RST_CROSSOVER  = 32'd14038323;
  localparam logic [CFG_W-1:0]  RST_DRIVE_LOW  = 32'd19152;
  localparam logic [CFG_W-1:0]  RST_DRIVE_MID  = 32'd1298;
  localparam logic [CFG_W-1:0]  RST_DRIVE_HIGH = 32'd463;
  localparam logic [CFG_W-1:0]  RST_TRIM       = 32'd0;
  localparam logic [GAIN_W-1:0] RST_SIDE_GAIN  = 18'd65536;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ design/three_band_crossover_distortion.sv @@
`timescale 1ns / 1ps

// Stereo three band crossover distortion. Each stereo input transaction yields
// one stereo output transaction. The sample pair is split into a side term and
// a mono sum; the sum runs through three one-pole crossover stages, and the
// low, mid and high bands are each soft clipped as x/(1+drive*|x|), scaled by
// their trim and mixed back with the side term, saturated to SAMPLE_WIDTH bits.
// Most of the time from acceptance of a pair to the next ready goes to the
// bit-serial divider, which produces one quotient bit per clock and runs once
// per band; the rest goes to the single shared multiplier, used ten times per
// pair under the sequencer. The input side is not ready while a pair is in
// work; a finished pair waits in the output register, so the next input can be
// taken before the previous result is drained.
// Configuration writes are taken at any time but must only be issued while idle.
module three_band_crossover_distortion #(
  parameter int SAMPLE_WIDTH = 24,
  localparam int TDATA_W = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration
  input  logic                            cfg_we_i,
  input  logic [2:0]                      cfg_addr_i,
  input  logic [tbcd_pkg::CFG_W-1:0]      cfg_wdata_i,
  // Input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [TDATA_W-1:0]              s_axis_tdata,  // left_in, right_in
  // Output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [TDATA_W-1:0]              m_axis_tdata   // left_out, right_out
);
  import tbcd_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int F     = SW - 1;
  localparam int QUO_W = F + 2;
  localparam longint DOPE    = ((longint'(1) <<< F) * 20 + 500000) / 1000000;
  localparam longint OUT_MAX = (longint'(1) <<< F) - 1;
  localparam longint OUT_MIN = -(longint'(1) <<< F);
  localparam longint ST_MAX  = 64'sd2147483647;
  localparam longint ST_MIN  = -64'sd2147483648;

  // Sequencer states
  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_SIDE     = 4'd1;
  localparam logic [3:0] ST_HI_MUL   = 4'd2;
  localparam logic [3:0] ST_HI_WB    = 4'd3;
  localparam logic [3:0] ST_LO1_MUL  = 4'd4;
  localparam logic [3:0] ST_LO1_WB   = 4'd5;
  localparam logic [3:0] ST_LO2_MUL  = 4'd6;
  localparam logic [3:0] ST_LO2_WB   = 4'd7;
  localparam logic [3:0] ST_BAND     = 4'd8;
  localparam logic [3:0] ST_MAG      = 4'd9;
  localparam logic [3:0] ST_DRV_MUL  = 4'd10;
  localparam logic [3:0] ST_DEN      = 4'd11;
  localparam logic [3:0] ST_DIV      = 4'd12;
  localparam logic [3:0] ST_TRIM_MUL = 4'd13;
  localparam logic [3:0] ST_ACC      = 4'd14;
  localparam logic [3:0] ST_OUT      = 4'd15;

  // Band codes
  localparam logic [1:0] BAND_LOW  = 2'd0;
  localparam logic [1:0] BAND_MID  = 2'd1;
  localparam logic [1:0] BAND_HIGH = 2'd2;

  // Configuration registers
  logic [CFG_W-1:0]  coefs_q, drive_low_q, drive_mid_q, drive_high_q;
  logic [CFG_W-1:0]  trim_low_q, trim_mid_q, trim_high_q;
  logic [GAIN_W-1:0] side_gain_q;

  // Control and filter state
  logic [3:0]                state_q;
  logic [1:0]                band_q;
  logic                      out_valid_q;
  logic signed [STATE_W-1:0] hi_q, lo1_q, lo2_q;

  // Working payload
  logic signed [SW-1:0]     left_q, right_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [SIDE_W-1:0] side_q;
  logic signed [BAND_W-1:0] x_q;
  logic                     neg_q;
  logic [QUO_W-1:0]         mag_q;
  logic [DEN_W-1:0]         den_q;
  logic signed [MIX_W-1:0]  mix_q;
  logic [SW-1:0]            out_left_q, out_right_q;

  // Datapath signals
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  round16;
  logic signed [STATE_W-1:0] pole_st;
  logic signed [ROUND_W-1:0] pole_sum;
  logic signed [STATE_W-1:0] pole_new;
  logic [62:0]               prod_sat;
  logic [DEN_W-1:0]          den_d;
  logic [TRIM_W-1:0]         trim_d;
  logic signed [BAND_W-1:0]  band_val;
  logic [BAND_W-1:0]         x_abs;
  logic [QUO_W-1:0]          mag_d;
  logic [CFG_W-1:0]          drive_sel, trim_sel;
  logic signed [MIX_W:0]     sum_left, sum_right;
  logic [SW-1:0]             left_sat, right_sat;
  logic                      s_accept;
  logic                      out_free;
  logic                      div_start;
  logic [QUO_W-1:0]          quo;
  div_stat_t                 div_stat;

  assign s_axis_tready = state_q == ST_IDLE;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign div_start     = state_q == ST_DEN;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coefs_q      <= RST_CROSSOVER;
      drive_low_q  <= RST_DRIVE_LOW;
      drive_mid_q  <= RST_DRIVE_MID;
      drive_high_q <= RST_DRIVE_HIGH;
      trim_low_q   <= RST_TRIM;
      trim_mid_q   <= RST_TRIM;
      trim_high_q  <= RST_TRIM;
      side_gain_q  <= RST_SIDE_GAIN;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_CROSSOVER:  coefs_q      <= cfg_wdata_i;
        REG_DRIVE_LOW:  drive_low_q  <= cfg_wdata_i;
        REG_DRIVE_MID:  drive_mid_q  <= cfg_wdata_i;
        REG_DRIVE_HIGH: drive_high_q <= cfg_wdata_i;
        REG_TRIM_LOW:   trim_low_q   <= cfg_wdata_i;
        REG_TRIM_MID:   trim_mid_q   <= cfg_wdata_i;
        REG_TRIM_HIGH:  trim_high_q  <= cfg_wdata_i;
        REG_SIDE_GAIN:  side_gain_q  <= cfg_wdata_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Select the band's drive and trim
  always_comb begin
    case (band_q)
      BAND_LOW: begin
        drive_sel = drive_low_q;
        trim_sel  = trim_low_q;
        band_val  = BAND_W'(lo2_q);
      end
      BAND_MID: begin
        drive_sel = drive_mid_q;
        trim_sel  = trim_mid_q;
        band_val  = BAND_W'(hi_q) - BAND_W'(lo2_q);
      end
      default: begin
        drive_sel = drive_high_q;
        trim_sel  = trim_high_q;
        band_val  = BAND_W'(sum_q) - BAND_W'(hi_q);
      end
    endcase
  end

  // Route operands into the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_SIDE: begin
        mul_a = MUL_A_W'(left_q) - MUL_A_W'(right_q);
        mul_b = MUL_B_W'(side_gain_q);
      end
      ST_HI_MUL: begin
        mul_a = MUL_A_W'(sum_q) - MUL_A_W'(hi_q);
        mul_b = MUL_B_W'(coefs_q[CFG_W-1:COEF_W]);
      end
      ST_LO1_MUL: begin
        mul_a = MUL_A_W'(hi_q) - MUL_A_W'(lo1_q);
        mul_b = MUL_B_W'(coefs_q[COEF_W-1:0]);
      end
      ST_LO2_MUL: begin
        mul_a = MUL_A_W'(lo1_q) - MUL_A_W'(lo2_q);
        mul_b = MUL_B_W'(coefs_q[COEF_W-1:0]);
      end
      ST_DRV_MUL: begin
        mul_a = signed'(MUL_A_W'(mag_q));
        mul_b = drive_sel;
      end
      ST_TRIM_MUL: begin
        mul_a = signed'(MUL_A_W'(quo));
        mul_b = trim_sel;
      end
      default: ;
    endcase
  end

  tbcd_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  tbcd_div #(
    .QUO_W (QUO_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .mag_i   (mag_q),
    .den_i   (den_q),
    .quo_o   (quo),
    .stat_o  (div_stat)
  );

  // Round the product to nearest, ties up, and apply to the filter state
  assign round16 = (prod + PROD_W'(32768)) >>> 16;

  always_comb begin
    case (state_q)
      ST_HI_WB:  pole_st = hi_q;
      ST_LO1_WB: pole_st = lo1_q;
      default:   pole_st = lo2_q;
    endcase
  end

  assign pole_sum = ROUND_W'(pole_st) + ROUND_W'(round16);

  always_comb begin
    if (longint'(pole_sum) > ST_MAX) begin
      pole_new = STATE_W'(ST_MAX);
    end else if (longint'(pole_sum) < ST_MIN) begin
      pole_new = STATE_W'(ST_MIN);
    end else begin
      pole_new = STATE_W'(pole_sum);
    end
  end

  // Saturate unsigned products at 2^62, then form denominator and trim level
  assign prod_sat = (prod > PROD_W'(64'sh4000_0000_0000_0000)) ?
                    {1'b1, 62'd0} : prod[62:0];
  assign den_d  = DEN_W'(longint'(1) <<< F) +
                  DEN_W'((64'(prod_sat) + 64'd2048) >> 12);
  assign trim_d = TRIM_W'((64'(prod_sat) + 64'd32768) >> 16);

  // Band magnitude, capped below 2^(F+2)
  assign x_abs = x_q[BAND_W-1] ? (~x_q + 1'b1) : x_q;
  assign mag_d = (x_abs > BAND_W'({QUO_W{1'b1}})) ? {QUO_W{1'b1}} : x_abs[QUO_W-1:0];

  // Output mix with side term, saturated to the sample range
  assign sum_left  = (MIX_W + 1)'(mix_q) + (MIX_W + 1)'(side_q);
  assign sum_right = (MIX_W + 1)'(mix_q) - (MIX_W + 1)'(side_q);

  always_comb begin
    if (longint'(sum_left) > OUT_MAX) begin
      left_sat = SW'(OUT_MAX);
    end else if (longint'(sum_left) < OUT_MIN) begin
      left_sat = SW'(OUT_MIN);
    end else begin
      left_sat = sum_left[SW-1:0];
    end
    if (longint'(sum_right) > OUT_MAX) begin
      right_sat = SW'(OUT_MAX);
    end else if (longint'(sum_right) < OUT_MIN) begin
      right_sat = SW'(OUT_MIN);
    end else begin
      right_sat = sum_right[SW-1:0];
    end
  end

  // Sequencer, band counter, filter state and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      band_q      <= BAND_LOW;
      out_valid_q <= 1'b0;
      hi_q        <= '0;
      lo1_q       <= '0;
      lo2_q       <= '0;
    end else begin
      // Load a finished pair, or drop the valid once the result is taken
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE:     if (s_accept) state_q <= ST_SIDE;
        ST_SIDE:     state_q <= ST_HI_MUL;
        ST_HI_MUL:   state_q <= ST_HI_WB;
        ST_HI_WB: begin
          hi_q    <= pole_new;
          state_q <= ST_LO1_MUL;
        end
        ST_LO1_MUL:  state_q <= ST_LO1_WB;
        ST_LO1_WB: begin
          lo1_q   <= pole_new;
          state_q <= ST_LO2_MUL;
        end
        ST_LO2_MUL:  state_q <= ST_LO2_WB;
        ST_LO2_WB: begin
          lo2_q   <= pole_new;
          band_q  <= BAND_LOW;
          state_q <= ST_BAND;
        end
        ST_BAND:     state_q <= ST_MAG;
        ST_MAG:      state_q <= ST_DRV_MUL;
        ST_DRV_MUL:  state_q <= ST_DEN;
        ST_DEN:      state_q <= ST_DIV;
        ST_DIV:      if (div_stat.done) state_q <= ST_TRIM_MUL;
        ST_TRIM_MUL: state_q <= ST_ACC;
        ST_ACC: begin
          if (band_q == BAND_HIGH) begin
            state_q <= ST_OUT;
          end else begin
            band_q  <= band_q + 1'b1;
            state_q <= ST_BAND;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default:     state_q <= ST_IDLE;
      endcase
    end
  end

  // Hold working values for the pair in progress
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      left_q  <= s_axis_tdata[SW-1:0];
      right_q <= s_axis_tdata[2*SW-1:SW];
    end
    if (state_q == ST_SIDE) begin
      sum_q <= SUM_W'(left_q) + SUM_W'(right_q) + SUM_W'(DOPE);
    end
    if (state_q == ST_HI_MUL) begin
      side_q <= SIDE_W'(round16);
    end
    if (state_q == ST_LO2_WB) begin
      mix_q <= '0;
    end
    if (state_q == ST_BAND) begin
      x_q <= band_val;
    end
    if (state_q == ST_MAG) begin
      mag_q <= mag_d;
      neg_q <= x_q[BAND_W-1];
    end
    if (state_q == ST_DEN) begin
      den_q <= den_d;
    end
    if (state_q == ST_ACC) begin
      if (neg_q) begin
        mix_q <= mix_q - signed'(MIX_W'(trim_d));
      end else begin
        mix_q <= mix_q + signed'(MIX_W'(trim_d));
      end
    end
    if (state_q == ST_OUT && out_free) begin
      out_left_q  <= left_sat;
      out_right_q <= right_sat;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TDATA_W'({out_right_q, out_left_q});

`ifndef SYNTH
  // The divider is never restarted while a division is running
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  // Waiting on the divider means it is really running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> div_stat.busy)
    else $error("sequencer waits on an idle divider");

  // A finished pair lands in the output register and the block goes idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_free) |=> (m_axis_tvalid && state_q == ST_IDLE))
    else $error("result not loaded into output register");
`endif

endmodule

@@ design/tbcd_mul.sv @@
`timescale 1ns / 1ps

module tbcd_mul (
  input  logic                                  clk_i,
  input  logic signed [tbcd_pkg::MUL_A_W-1:0]   a_i,
  input  logic        [tbcd_pkg::MUL_B_W-1:0]   b_i,
  output logic signed [tbcd_pkg::PROD_W-1:0]    prod_o
);
  import tbcd_pkg::*;

  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] prod_q;

  // Signed by unsigned product
  assign prod_d = PROD_W'(a_i) * PROD_W'(signed'({1'b0, b_i}));

  // Register every product
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

@@ design/tbcd_div.sv @@
`timescale 1ns / 1ps

module tbcd_div #(
  parameter int QUO_W = 25
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [QUO_W-1:0]              mag_i,
  input  logic [tbcd_pkg::DEN_W-1:0]    den_i,
  output logic [QUO_W-1:0]              quo_o,
  output tbcd_pkg::div_stat_t           stat_o
);
  import tbcd_pkg::*;

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [QUO_W-1:0] work_q, work_d;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             fits;

  // One restoring step: bring in the next dividend bit, try the subtract
  assign shifted = {rem_q, work_q[QUO_W-1]};
  assign diff    = shifted - {1'b0, den_i};
  assign fits    = shifted >= {1'b0, den_i};
  assign rem_d   = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
  assign work_d  = {work_q[QUO_W-2:0], fits};

  // Sequence the steps, one quotient bit per clock
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(QUO_W);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= cnt_q != CNT_W'(1);
    end
  end

  // Dividend is mag shifted up by QUO_W-2; the top part starts the remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= DEN_W'(mag_i >> 2);
      work_q <= {mag_i[1:0], {(QUO_W - 2){1'b0}}};
    end else if (busy_q) begin
      rem_q  <= rem_d;
      work_q <= work_d;
    end
  end

  assign quo_o       = work_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = busy_q && (cnt_q == CNT_W'(1));

endmodule
